[rtl/sync_sum_frame_receiver_defines.svh]
// Assertion macros shared by the frame receiver RTL.
`ifndef SYNC_SUM_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_SUM_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSCFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sscfr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSCFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sscfr assertion failed");

`endif

[rtl/sscfr_pkg.sv]
// Types, codes and constants of the sync/sum frame receiver.
`default_nettype none
package sscfr_pkg;

   localparam int FRAME_BYTES_DEFAULT = 53;
   localparam int DATA_W              = 8;
   localparam int READ_INDEX_W        = 6;
   localparam int SUM_W               = 16;
   localparam int CSR_INDEX_W         = 2;

   typedef enum logic [1:0] {
      FUNC_RX_BYTE = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_READ    = 2'd2,
      FUNC_RELEASE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_TAKEN      = 3'd0,
      ST_ACCEPTED   = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_BAD_SUM    = 3'd3,
      ST_DROPPED    = 3'd4,
      ST_TIMEOUT    = 3'd5,
      ST_RELEASED   = 3'd6,
      ST_READ       = 3'd7
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_SYNC_FIRST    = 2'd0,
      CFG_SYNC_SECOND   = 2'd1,
      CFG_LENGTH_CODE   = 2'd2,
      CFG_TIMEOUT_TICKS = 2'd3
   } cfg_index_type;

   localparam logic [DATA_W-1:0] SYNC_FIRST_RESET    = 8'h55;
   localparam logic [DATA_W-1:0] SYNC_SECOND_RESET   = 8'hAA;
   localparam logic [DATA_W-1:0] LENGTH_CODE_RESET   = 8'd48;
   localparam logic [DATA_W-1:0] TIMEOUT_TICKS_RESET = 8'd2;
   localparam logic [DATA_W-1:0] TICKS_MAX           = 8'hFF;

   typedef struct packed {
      func_type                  func;
      logic [DATA_W-1:0]         rx_byte;
      logic [READ_INDEX_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [DATA_W-1:0]         read_data;
      logic                      frame_held;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] sync_first;
      logic [DATA_W-1:0] sync_second;
      logic [DATA_W-1:0] length_code;
      logic [DATA_W-1:0] timeout_ticks;
   } cfg_type;

   // Per-transaction outcome from the frame controller; read_ok means the
   // bank memory was read for this transaction.
   typedef struct packed {
      status_type status;
      logic       read_ok;
      logic       frame_held;
   } ctrl_result_type;

endpackage
`default_nettype wire

[rtl/sync_sum_frame_receiver.sv]
// Top level of the sync/sum frame receiver.
// Receives fixed frames of FRAME_BYTES bytes (5..63) into one of two banks of a
// single 2*FRAME_BYTES x 8 memory. Each req transaction is a received byte, a
// timer tick, a read of the held frame or a release, and yields exactly one rsp
// transaction, in order. A frame is sync_first, sync_second, length_code,
// payload, then a little-endian 16-bit sum of all bytes before the sum; a good
// frame is held by swapping banks unless a frame is already held. Throughput is
// one transaction per clock unless rsp_ready holds back the output register:
// the bank memory takes one write (byte) or one read (held-byte read) each
// cycle and all frame state lives in flops. rsp_valid is registered: an
// accepted req goes through stage 1, which waits for the memory read, and
// then the output register, which drives the rsp transaction. The memory
// needs no clearing pass after reset; only held banks are read, and they are
// always fully written. Configuration writes take effect the next cycle and
// must be made while no transaction is in flight.
`default_nettype none
`include "sync_sum_frame_receiver_defines.svh"
module sync_sum_frame_receiver #(
   parameter int FRAME_BYTES = sscfr_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sscfr_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sscfr_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_wen,
   input  logic [sscfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sscfr_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int DEPTH  = 2 * FRAME_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   sscfr_pkg::cfg_type          cfg;
   sscfr_pkg::ctrl_result_type  result;
   logic                        accept;
   logic                        mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]           mem_wr_addr, mem_rd_addr;
   logic [sscfr_pkg::DATA_W-1:0] mem_wr_data, mem_rd_data;

   // Stage 1 waits for the memory read; the output register then parts the
   // req side from a stalled rsp side.
   logic                        s1_valid_ff, s1_valid_in;
   sscfr_pkg::ctrl_result_type  s1_ff;
   logic                        s1_adv;
   logic                        rsp_valid_ff, rsp_valid_in;
   sscfr_pkg::rsp_type          rsp_ff;

   sscfr_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sscfr_frame_ctrl #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .cfg         (cfg),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   sscfr_bank_mem #(
      .DEPTH (DEPTH)
   ) u_bank_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register empties or drains this cycle -> stage 1 moves on.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Memory read data stays put while stage 1 stalls because no new
   // transaction is taken then.
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= result;
      end
      if (s1_adv) begin
         rsp_ff.status     <= s1_ff.status;
         rsp_ff.read_data  <= s1_ff.read_ok ? mem_rd_data : '0;
         rsp_ff.frame_held <= s1_ff.frame_held;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SSCFR_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, s1_valid_ff)

endmodule
`default_nettype wire

[rtl/sscfr_cfg_regs.sv]
// Configuration register file of the frame receiver.
`default_nettype none
module sscfr_cfg_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [sscfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sscfr_pkg::DATA_W-1:0]          csr_wdata,
   output sscfr_pkg::cfg_type                    cfg
);

   sscfr_pkg::cfg_type cfg_ff;
   sscfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (sscfr_pkg::cfg_index_type'(csr_index))
            sscfr_pkg::CFG_SYNC_FIRST:    cfg_in.sync_first    = csr_wdata;
            sscfr_pkg::CFG_SYNC_SECOND:   cfg_in.sync_second   = csr_wdata;
            sscfr_pkg::CFG_LENGTH_CODE:   cfg_in.length_code   = csr_wdata;
            sscfr_pkg::CFG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= sscfr_pkg::SYNC_FIRST_RESET;
         cfg_ff.sync_second   <= sscfr_pkg::SYNC_SECOND_RESET;
         cfg_ff.length_code   <= sscfr_pkg::LENGTH_CODE_RESET;
         cfg_ff.timeout_ticks <= sscfr_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/sscfr_bank_mem.sv]
// Ping-pong frame bank memory: one write port, one registered read port.
`default_nettype none
module sscfr_bank_mem #(
   parameter int DEPTH = 2 * sscfr_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [sscfr_pkg::DATA_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [sscfr_pkg::DATA_W-1:0]      rd_data
);

   logic [sscfr_pkg::DATA_W-1:0] mem [DEPTH];
   logic [sscfr_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/sscfr_frame_ctrl.sv]
// Frame assembly, header/sum check, timeout and hold control.
`default_nettype none
`include "sync_sum_frame_receiver_defines.svh"
module sscfr_frame_ctrl #(
   parameter int FRAME_BYTES = sscfr_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  sscfr_pkg::req_type                      req,
   input  sscfr_pkg::cfg_type                      cfg,
   output logic                                    mem_wr_en,
   output logic [$clog2(2*FRAME_BYTES)-1:0]        mem_wr_addr,
   output logic [sscfr_pkg::DATA_W-1:0]            mem_wr_data,
   output logic                                    mem_rd_en,
   output logic [$clog2(2*FRAME_BYTES)-1:0]        mem_rd_addr,
   output sscfr_pkg::ctrl_result_type              result
);

   localparam int POS_W  = $clog2(FRAME_BYTES);
   localparam int ADDR_W = $clog2(2 * FRAME_BYTES);
   localparam int IW     = sscfr_pkg::READ_INDEX_W;
   localparam int DW     = sscfr_pkg::DATA_W;
   localparam int SW     = sscfr_pkg::SUM_W;

   localparam logic [POS_W-1:0]  POS_SYNC1 = POS_W'(0);
   localparam logic [POS_W-1:0]  POS_SYNC2 = POS_W'(1);
   localparam logic [POS_W-1:0]  POS_LEN   = POS_W'(2);
   localparam logic [POS_W-1:0]  POS_SUMLO = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_BYTES - 1);
   localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(FRAME_BYTES);
   localparam logic [IW-1:0]     IDX_LIMIT  = IW'(FRAME_BYTES);

   logic              fill_bank_ff,  fill_bank_in;
   logic              held_bank_ff,  held_bank_in;
   logic [POS_W-1:0]  byte_count_ff, byte_count_in;
   logic [SW-1:0]     sum_ff,        sum_in;
   logic [DW-1:0]     sum_lo_ff,     sum_lo_in;
   logic              hdr_good_ff,   hdr_good_in;
   logic              started_ff,    started_in;
   logic [DW-1:0]     ticks_ff,      ticks_in;
   logic              hold_ff,       hold_in;

   logic              hdr_now;
   logic [DW-1:0]     ticks_inc;
   logic              read_ok;
   logic              accept_hold;

   assign ticks_inc = (ticks_ff == sscfr_pkg::TICKS_MAX) ? ticks_ff : ticks_ff + DW'(1);
   assign read_ok   = hold_ff && (req.read_index < IDX_LIMIT);
   assign accept_hold = accept && (result.status == sscfr_pkg::ST_ACCEPTED);

   always_comb begin
      fill_bank_in  = fill_bank_ff;
      held_bank_in  = held_bank_ff;
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      sum_lo_in     = sum_lo_ff;
      hdr_good_in   = hdr_good_ff;
      started_in    = started_ff;
      ticks_in      = ticks_ff;
      hold_in       = hold_ff;
      hdr_now       = hdr_good_ff;
      result.status = sscfr_pkg::ST_TAKEN;
      result.read_ok = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      if (accept) begin
         case (req.func)
            sscfr_pkg::FUNC_RX_BYTE: begin
               mem_wr_en = 1'b1;
               if (byte_count_ff == POS_SYNC1) begin
                  started_in = 1'b1;
                  ticks_in   = '0;
               end
               if (byte_count_ff == POS_SYNC1 && req.rx_byte != cfg.sync_first) begin
                  hdr_now = 1'b0;
               end
               if (byte_count_ff == POS_SYNC2 && req.rx_byte != cfg.sync_second) begin
                  hdr_now = 1'b0;
               end
               if (byte_count_ff == POS_LEN && req.rx_byte != cfg.length_code) begin
                  hdr_now = 1'b0;
               end
               hdr_good_in = hdr_now;
               if (byte_count_ff < POS_SUMLO) begin
                  sum_in = sum_ff + SW'(req.rx_byte);
               end
               if (byte_count_ff == POS_SUMLO) begin
                  sum_lo_in = req.rx_byte;
               end
               if (byte_count_ff != POS_LAST) begin
                  byte_count_in = byte_count_ff + POS_W'(1);
               end else begin
                  // Frame complete: header first, then sum, then hold.
                  if (!hdr_now) begin
                     result.status = sscfr_pkg::ST_BAD_HEADER;
                  end else if ({req.rx_byte, sum_lo_ff} != sum_ff) begin
                     result.status = sscfr_pkg::ST_BAD_SUM;
                  end else if (hold_ff) begin
                     result.status = sscfr_pkg::ST_DROPPED;
                  end else begin
                     result.status = sscfr_pkg::ST_ACCEPTED;
                     hold_in       = 1'b1;
                     held_bank_in  = fill_bank_ff;
                     fill_bank_in  = ~fill_bank_ff;
                  end
                  byte_count_in = '0;
                  sum_in        = '0;
                  hdr_good_in   = 1'b1;
                  started_in    = 1'b0;
                  ticks_in      = '0;
               end
            end
            sscfr_pkg::FUNC_TICK: begin
               if (started_ff) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc > cfg.timeout_ticks) begin
                     result.status = sscfr_pkg::ST_TIMEOUT;
                     byte_count_in = '0;
                     sum_in        = '0;
                     hdr_good_in   = 1'b1;
                     started_in    = 1'b0;
                     ticks_in      = '0;
                  end
               end
            end
            sscfr_pkg::FUNC_READ: begin
               result.status  = sscfr_pkg::ST_READ;
               result.read_ok = read_ok;
               mem_rd_en      = read_ok;
            end
            default: begin
               result.status = sscfr_pkg::ST_RELEASED;
               hold_in       = 1'b0;
            end
         endcase
      end
      result.frame_held = hold_in;
   end

   assign mem_wr_addr = (fill_bank_ff ? BANK1_BASE : '0) + ADDR_W'(byte_count_ff);
   assign mem_wr_data = req.rx_byte;
   assign mem_rd_addr = (held_bank_ff ? BANK1_BASE : '0) +
                        ADDR_W'(req.read_index[POS_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_bank_ff  <= 1'b0;
         held_bank_ff  <= 1'b1;
         byte_count_ff <= '0;
         sum_ff        <= '0;
         hdr_good_ff   <= 1'b1;
         started_ff    <= 1'b0;
         ticks_ff      <= '0;
         hold_ff       <= 1'b0;
      end else begin
         fill_bank_ff  <= fill_bank_in;
         held_bank_ff  <= held_bank_in;
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         hdr_good_ff   <= hdr_good_in;
         started_ff    <= started_in;
         ticks_ff      <= ticks_in;
         hold_ff       <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_lo_ff <= sum_lo_in;
   end

   `SSCFR_ASSERT_NOW(a_banks_differ, 1'b1, fill_bank_ff != held_bank_ff)
   `SSCFR_ASSERT_NOW(a_count_needs_start, byte_count_ff != '0, started_ff)
   `SSCFR_ASSERT_NEXT(a_accept_holds, accept_hold, hold_ff && held_bank_ff != $past(held_bank_ff))

endmodule
`default_nettype wire
